/* rtl/stt_pkg.sv */
// Package for the source text tokenizer: scan modes, token kinds, the token
// record and the keyword classifier. No dependencies.
`default_nettype none
package stt_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int MAX_NESTING_DEF = 255;

    typedef enum logic [4:0] {
        M_IDLE, M_SLASH, M_LINECOM, M_BLOCK, M_BLOCK_SLASH, M_BLOCK_STAR,
        M_DOT, M_DOTDOT, M_EQ, M_BANG, M_LT, M_GT, M_PIPE, M_AMP, M_COLON,
        M_HASH, M_HASHBS, M_STRING, M_DIRECTIVE, M_IDENT, M_ZERO, M_HEX0,
        M_HEX, M_DEC
    } mode_t;

    localparam logic [5:0] K_INVALID   = 6'd0;
    localparam logic [5:0] K_IDENT     = 6'd1;
    localparam logic [5:0] K_NUM       = 6'd2;
    localparam logic [5:0] K_DOLLAR    = 6'd3;
    localparam logic [5:0] K_STRING    = 6'd4;
    localparam logic [5:0] K_CHARACTER = 6'd5;
    localparam logic [5:0] K_SEMICOLON = 6'd6;
    localparam logic [5:0] K_COLON     = 6'd7;
    localparam logic [5:0] K_DCOLON    = 6'd8;
    localparam logic [5:0] K_COLON_EQ  = 6'd9;
    localparam logic [5:0] K_EQUALS    = 6'd10;
    localparam logic [5:0] K_EQEQ      = 6'd11;
    localparam logic [5:0] K_NOT_EQ    = 6'd12;
    localparam logic [5:0] K_COMMA     = 6'd13;
    localparam logic [5:0] K_DOTDOT    = 6'd14;
    localparam logic [5:0] K_DOTDOTEQ  = 6'd15;
    localparam logic [5:0] K_DOT       = 6'd16;
    localparam logic [5:0] K_QUESTION  = 6'd17;
    localparam logic [5:0] K_LBRACE    = 6'd18;
    localparam logic [5:0] K_RBRACE    = 6'd19;
    localparam logic [5:0] K_LSQ       = 6'd20;
    localparam logic [5:0] K_RSQ       = 6'd21;
    localparam logic [5:0] K_LPAREN    = 6'd22;
    localparam logic [5:0] K_RPAREN    = 6'd23;
    localparam logic [5:0] K_PIPE      = 6'd24;
    localparam logic [5:0] K_LOR       = 6'd25;
    localparam logic [5:0] K_BOR       = 6'd26;
    localparam logic [5:0] K_LAND      = 6'd27;
    localparam logic [5:0] K_AMPERSAND = 6'd28;
    localparam logic [5:0] K_XOR       = 6'd29;
    localparam logic [5:0] K_NOT       = 6'd30;
    localparam logic [5:0] K_LT        = 6'd31;
    localparam logic [5:0] K_LTEQ      = 6'd32;
    localparam logic [5:0] K_GT        = 6'd33;
    localparam logic [5:0] K_GTEQ      = 6'd34;
    localparam logic [5:0] K_PLUS      = 6'd35;
    localparam logic [5:0] K_MINUS     = 6'd36;
    localparam logic [5:0] K_ASTERISK  = 6'd37;
    localparam logic [5:0] K_SLASH     = 6'd38;
    localparam logic [5:0] K_PERCENT   = 6'd39;
    localparam logic [5:0] K_RARROW    = 6'd59;
    localparam logic [5:0] K_DIRECTIVE = 6'd60;
    localparam logic [5:0] K_NEWLINE   = 6'd61;
    localparam logic [5:0] K_END       = 6'd62;
    localparam logic [5:0] K_NONE      = 6'd63;

    localparam logic [23:0] OUT_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic [5:0]  kind;
        logic [23:0] start;
        logic [23:0] len;
        logic [23:0] line;
    } tok_t;

    function automatic logic is_dec(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_letter(c) || is_dec(c) || c == "_";
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dec(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    // Second byte of a two-byte operator; K_NONE when c does not continue it.
    function automatic logic [5:0] pair_kind(input mode_t m, input logic [7:0] c);
        logic [5:0] k;
        k = K_NONE;
        unique case (m)
            M_EQ:    k = (c == "=") ? K_EQEQ : ((c == ">") ? K_RARROW : K_NONE);
            M_BANG:  k = (c == "=") ? K_NOT_EQ : K_NONE;
            M_LT:    k = (c == "=") ? K_LTEQ : K_NONE;
            M_GT:    k = (c == "=") ? K_GTEQ : K_NONE;
            M_PIPE:  k = (c == "|") ? K_LOR : ((c == ">") ? K_PIPE : K_NONE);
            M_AMP:   k = (c == "&") ? K_LAND : K_NONE;
            M_COLON: k = (c == "=") ? K_COLON_EQ : ((c == ":") ? K_DCOLON : K_NONE);
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    // Turns a right-aligned string literal into first-byte-lowest order.
    function automatic logic [47:0] rev6(input logic [47:0] s, input int len);
        logic [47:0] r;
        r = '0;
        for (int j = 0; j < 6; j++) begin
            if (j < len) begin
                r[8*j +: 8] = s[8*(len-1-j) +: 8];
            end
        end
        return r;
    endfunction

    function automatic logic kw_hit(input logic [47:0] w, input logic [2:0] n,
                                    input logic [47:0] s, input int len);
        return (n == 3'(len)) && (w == rev6(s, len));
    endfunction

    function automatic logic [5:0] classify(input logic [47:0] w, input logic [2:0] n);
        logic [5:0] k;
        k = K_IDENT;
        if      (kw_hit(w, n, "func", 4))   k = 6'd44;
        else if (kw_hit(w, n, "true", 4))   k = 6'd45;
        else if (kw_hit(w, n, "false", 5))  k = 6'd46;
        else if (kw_hit(w, n, "if", 2))     k = 6'd48;
        else if (kw_hit(w, n, "else", 4))   k = 6'd49;
        else if (kw_hit(w, n, "struct", 6)) k = 6'd55;
        else if (kw_hit(w, n, "case", 4))   k = 6'd50;
        else if (kw_hit(w, n, "cffi", 4))   k = 6'd43;
        else if (kw_hit(w, n, "return", 6)) k = 6'd47;
        else if (kw_hit(w, n, "main", 4))   k = 6'd51;
        else if (kw_hit(w, n, "nil", 3))    k = 6'd56;
        else if (kw_hit(w, n, "for", 3))    k = 6'd52;
        else if (kw_hit(w, n, "in", 2))     k = 6'd53;
        else if (kw_hit(w, n, "ref", 3))    k = 6'd58;
        else if (kw_hit(w, n, "var", 3))    k = 6'd40;
        else if (kw_hit(w, n, "const", 5))  k = 6'd41;
        else if (kw_hit(w, n, "while", 5))  k = 6'd54;
        return k;
    endfunction

endpackage
`default_nettype wire

/* rtl/source_text_tokenizer.sv */
// Top level of the source text tokenizer: scanner state, per-beat token
// logic and a four-entry token queue. Depends on stt_pkg.
//
//   channel  | dir | beat carries
//   s_*      | in  | tdata: text_byte[7:0]; tlast: end_of_text
//   m_*      | out | tdata: start_offset, token_length, line_number; tuser: token_kind;
//            |     | tlast: run_last
//
// One input beat is taken per cycle while the token queue has room for two
// entries; each beat pushes zero to two tokens in the same cycle it is taken.
// Tokens reach m_* from the registered token queue, never combinationally.
// Throughput is one byte per cycle while the queue keeps room for two entries; a stall
// on m_tready fills the queue and then holds s_tready low.
// Reset clears the scanner to the start of a text; no clearing pass.
`default_nettype none
module source_text_tokenizer #(
    parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
    parameter int MAX_NESTING = stt_pkg::MAX_NESTING_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // text_byte[7:0]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // start_offset[23:0], token_length[47:24],
                                        // line_number[71:48]
    output logic [5:0]       m_tuser,   // token_kind[5:0]
    output logic             m_tlast
);
    import stt_pkg::*;

    localparam int OB = OFFSET_BITS;
    localparam int W  = (OB + 1 > 25) ? OB + 1 : 25;
    localparam int DW = $clog2(MAX_NESTING + 1);
    localparam logic [OB-1:0] POS_MAX = '1;

    typedef struct packed {
        mode_t           mode;
        logic [OB-1:0]   tstart;
        logic [5:0]      pk;
        logic [47:0]     wbytes;
        logic [2:0]      wlen;
        logic [DW-1:0]   depth;
        logic            cnl;
        logic            lsf;
        logic [23:0]     line;
        logic [2:0]      cnt;
        tok_t [3:0]      res;
        logic            redo;
    } lex_t;

    typedef struct packed {
        tok_t tok;
        logic last;
    } qent_t;

    function automatic logic [23:0] sat24(input logic [W-1:0] v);
        return (v > W'(OUT_MAX)) ? OUT_MAX : v[23:0];
    endfunction

    function automatic lex_t put(input lex_t s, input logic [5:0] k,
                                 input logic [23:0] st, input logic [23:0] ln);
        lex_t r;
        r = s;
        if (r.cnt < 3'd4) begin
            r.res[r.cnt[1:0]] = '{kind: k, start: st, len: ln, line: r.line};
            r.cnt = r.cnt + 3'd1;
        end
        return r;
    endfunction

    function automatic lex_t tok(input lex_t s, input logic [5:0] k,
                                 input logic [OB-1:0] st, input logic [23:0] ln);
        lex_t r;
        r = put(s, k, sat24(W'(st)), ln);
        r.lsf = 1'b0;
        return r;
    endfunction

    function automatic lex_t mark(input lex_t s, input logic [OB-1:0] st);
        lex_t r;
        r = put(s, K_NEWLINE, sat24(W'(st)), 24'd0);
        r.cnl = 1'b0;
        r.lsf = 1'b1;
        return r;
    endfunction

    function automatic lex_t pend(input lex_t s, input logic [OB-1:0] p, input logic plus1);
        lex_t r;
        logic [5:0] k;
        logic [W-1:0] len;
        k = (s.mode == M_IDENT) ? classify(s.wbytes, s.wlen) : s.pk;
        len = W'(p) + W'(plus1) - W'(s.tstart);
        r = tok(s, k, s.tstart, sat24(len));
        r.mode = M_IDLE;
        return r;
    endfunction

    function automatic lex_t start(input lex_t s, input mode_t m, input logic [5:0] k,
                                   input logic [OB-1:0] p);
        lex_t r;
        r = s;
        r.mode = m;
        r.pk = k;
        r.tstart = p;
        return r;
    endfunction

    function automatic lex_t idle_byte(input lex_t s, input logic [7:0] c,
                                       input logic [OB-1:0] p);
        lex_t r;
        r = s;
        if (c == " " || c == 8'h09 || c == 8'h0D) begin
            r = s;
        end else if (c == "/") begin
            r.mode = M_SLASH;
            r.tstart = p;
        end else begin
            if (r.cnl) begin
                r = mark(r, p);
            end
            if (c == 8'h0A) begin
                r = put(r, K_NEWLINE, sat24(W'(p)), 24'd1);
                if (r.line < OUT_MAX) begin
                    r.line = r.line + 24'd1;
                end
                r.lsf = 1'b1;
            end
            else if (c == ";") r = tok(r, K_SEMICOLON, p, 24'd1);
            else if (c == ",") r = tok(r, K_COMMA, p, 24'd1);
            else if (c == "{") r = tok(r, K_LBRACE, p, 24'd1);
            else if (c == "}") r = tok(r, K_RBRACE, p, 24'd1);
            else if (c == "(") r = tok(r, K_LPAREN, p, 24'd1);
            else if (c == ")") r = tok(r, K_RPAREN, p, 24'd1);
            else if (c == "[") r = tok(r, K_LSQ, p, 24'd1);
            else if (c == "]") r = tok(r, K_RSQ, p, 24'd1);
            else if (c == "$") r = tok(r, K_DOLLAR, p, 24'd1);
            else if (c == "+") r = tok(r, K_PLUS, p, 24'd1);
            else if (c == "-") r = tok(r, K_MINUS, p, 24'd1);
            else if (c == "*") r = tok(r, K_ASTERISK, p, 24'd1);
            else if (c == "^") r = tok(r, K_XOR, p, 24'd1);
            else if (c == "?") r = tok(r, K_QUESTION, p, 24'd1);
            else if (c == ".") r = start(r, M_DOT, K_DOT, p);
            else if (c == "=") r = start(r, M_EQ, K_EQUALS, p);
            else if (c == "!") r = start(r, M_BANG, K_NOT, p);
            else if (c == "<") r = start(r, M_LT, K_LT, p);
            else if (c == ">") r = start(r, M_GT, K_GT, p);
            else if (c == "|") r = start(r, M_PIPE, K_BOR, p);
            else if (c == "&") r = start(r, M_AMP, K_AMPERSAND, p);
            else if (c == ":") r = start(r, M_COLON, K_COLON, p);
            else if (c == "#") r = start(r, M_HASH, K_INVALID, p);
            else if (c == 8'h22) r = start(r, M_STRING, K_STRING, p);
            else if (c == "%") begin
                if (r.lsf) r = start(r, M_DIRECTIVE, K_PERCENT, p);
                else       r = tok(r, K_PERCENT, p, 24'd1);
            end
            else if (c == "0") r = start(r, M_ZERO, K_NUM, p);
            else if (is_letter(c) || c == "_") begin
                r = start(r, M_IDENT, K_IDENT, p);
                r.wbytes = {40'd0, c};
                r.wlen = 3'd1;
            end
            else if (is_dec(c)) r = start(r, M_DEC, K_NUM, p);
            else r = tok(r, K_INVALID, p, 24'd1);
        end
        return r;
    endfunction

    // One scan step; a redo always lands in idle or in a block comment, so two
    // steps cover every byte.
    function automatic lex_t step(input lex_t s, input logic [7:0] c,
                                  input logic [OB-1:0] p);
        lex_t r;
        logic [5:0] k;
        r = s;
        r.redo = 1'b0;
        k = pair_kind(s.mode, c);
        unique case (s.mode)
            M_IDLE: r = idle_byte(r, c, p);
            M_SLASH: begin
                if (c == "/") r.mode = M_LINECOM;
                else if (c == "*") begin
                    r.mode = M_BLOCK;
                    r.depth = DW'(1);
                    r.cnl = 1'b0;
                end else begin
                    if (r.cnl) r = mark(r, r.tstart);
                    r = tok(r, K_SLASH, r.tstart, 24'd1);
                    r.mode = M_IDLE;
                    r.redo = 1'b1;
                end
            end
            M_LINECOM: begin
                if (c == 8'h0A) begin
                    r.mode = M_IDLE;
                    r.redo = 1'b1;
                end
            end
            M_BLOCK: begin
                if (c == 8'h0A) r.cnl = 1'b1;
                else if (c == "/") r.mode = M_BLOCK_SLASH;
                else if (c == "*") r.mode = M_BLOCK_STAR;
            end
            M_BLOCK_SLASH: begin
                r.mode = M_BLOCK;
                if (c == "*") begin
                    if (r.depth < DW'(MAX_NESTING)) r.depth = r.depth + DW'(1);
                end else begin
                    r.redo = 1'b1;
                end
            end
            M_BLOCK_STAR: begin
                r.mode = M_BLOCK;
                if (c == "/") begin
                    if (r.depth != '0) r.depth = r.depth - DW'(1);
                    if (r.depth == '0) r.mode = M_IDLE;
                end else begin
                    r.redo = 1'b1;
                end
            end
            M_DOT: begin
                if (c == ".") begin
                    r.mode = M_DOTDOT;
                    r.pk = K_DOTDOT;
                end else begin
                    r = pend(r, p, 1'b0);
                    r.redo = 1'b1;
                end
            end
            M_DOTDOT: begin
                if (c == "=") begin
                    r.pk = K_DOTDOTEQ;
                    r = pend(r, p, 1'b1);
                end else begin
                    r = pend(r, p, 1'b0);
                    r.redo = 1'b1;
                end
            end
            M_EQ, M_BANG, M_LT, M_GT, M_PIPE, M_AMP, M_COLON: begin
                if (k != K_NONE) begin
                    r.pk = k;
                    r = pend(r, p, 1'b1);
                end else begin
                    r = pend(r, p, 1'b0);
                    r.redo = 1'b1;
                end
            end
            M_HASH: begin
                if (c == 8'h5C) begin
                    r.mode = M_HASHBS;
                    r.pk = K_CHARACTER;
                end else begin
                    r = pend(r, p, 1'b0);
                    r.redo = 1'b1;
                end
            end
            M_HASHBS: r = pend(r, p, 1'b1);
            M_STRING: begin
                if (c == 8'h22) r = pend(r, p, 1'b1);
            end
            M_DIRECTIVE: begin
                if (is_word(c)) r.pk = K_DIRECTIVE;
                else begin
                    r = pend(r, p, 1'b0);
                    r.redo = 1'b1;
                end
            end
            M_IDENT: begin
                if (is_word(c)) begin
                    if (r.wlen < 3'd6) r.wbytes[8*r.wlen +: 8] = c;
                    if (r.wlen != 3'd7) r.wlen = r.wlen + 3'd1;
                end else begin
                    r = pend(r, p, 1'b0);
                    r.redo = 1'b1;
                end
            end
            M_ZERO: begin
                if (c == "x" || c == "X") begin
                    r.mode = M_HEX0;
                    r.pk = K_INVALID;
                end else if (is_dec(c)) begin
                    r.mode = M_DEC;
                end else begin
                    r = pend(r, p, 1'b0);
                    r.redo = 1'b1;
                end
            end
            M_HEX0: begin
                if (is_hex(c)) begin
                    r.mode = M_HEX;
                    r.pk = K_NUM;
                end else begin
                    r = pend(r, p, 1'b0);
                    r.redo = 1'b1;
                end
            end
            M_HEX: begin
                if (!is_hex(c)) begin
                    r = pend(r, p, 1'b0);
                    r.redo = 1'b1;
                end
            end
            M_DEC: begin
                if (!is_dec(c)) begin
                    r = pend(r, p, 1'b0);
                    r.redo = 1'b1;
                end
            end
            default: begin
                r.mode = M_IDLE;
                r.redo = 1'b1;
            end
        endcase
        return r;
    endfunction

    function automatic lex_t flush(input lex_t s, input logic [OB-1:0] p);
        lex_t r;
        r = s;
        unique case (s.mode)
            M_IDLE, M_LINECOM, M_BLOCK, M_BLOCK_SLASH, M_BLOCK_STAR: begin
                if (r.cnl) r = mark(r, p);
            end
            M_SLASH: begin
                if (r.cnl) r = mark(r, r.tstart);
                r = tok(r, K_SLASH, r.tstart, 24'd1);
            end
            default: r = pend(r, p, 1'b0);
        endcase
        r = put(r, K_END, sat24(W'(p)), 24'd0);
        return r;
    endfunction

    // Scanner registers.
    mode_t          mode_reg, mode_next;
    logic [OB-1:0]  pos_reg, pos_next;
    logic [OB-1:0]  tstart_reg, tstart_next;
    logic [5:0]     pk_reg, pk_next;
    logic [47:0]    wbytes_reg, wbytes_next;
    logic [2:0]     wlen_reg, wlen_next;
    logic [DW-1:0]  depth_reg, depth_next;
    logic           cnl_reg, cnl_next;
    logic           lsf_reg, lsf_next;
    logic [23:0]    line_reg, line_next;
    logic           held_valid_reg, held_valid_next;
    tok_t           held_reg, held_next;

    // Token queue.
    qent_t          q_mem [4];
    logic [1:0]     q_wr_reg, q_rd_reg;
    logic [2:0]     q_cnt_reg;

    logic           s_fire;
    logic           m_fire;
    lex_t           cur;
    lex_t           res;
    logic [1:0]     n_push;

    assign s_tready = (q_cnt_reg <= 3'd2);
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;

    always_comb
    begin
        cur = '{mode: mode_reg, tstart: tstart_reg, pk: pk_reg, wbytes: wbytes_reg,
                wlen: wlen_reg, depth: depth_reg, cnl: cnl_reg, lsf: lsf_reg,
                line: line_reg, cnt: 3'd0, res: '0, redo: 1'b0};
        if (held_valid_reg) begin
            cur.res[0] = held_reg;
            cur.cnt = 3'd1;
        end
        if (s_tlast) begin
            res = flush(cur, pos_reg);
        end else begin
            res = step(cur, s_tdata, pos_reg);
            if (res.redo) begin
                res = step(res, s_tdata, pos_reg);
            end
        end

        mode_next = res.mode;
        tstart_next = res.tstart;
        pk_next = res.pk;
        wbytes_next = res.wbytes;
        wlen_next = res.wlen;
        depth_next = res.depth;
        cnl_next = res.cnl;
        lsf_next = res.lsf;
        line_next = res.line;
        pos_next = (pos_reg != POS_MAX) ? pos_reg + OB'(1) : pos_reg;
        if (s_tlast) begin
            // Rearm for the next text.
            mode_next = M_IDLE;
            pos_next = '0;
            line_next = 24'd1;
            tstart_next = '0;
            pk_next = K_INVALID;
            wbytes_next = '0;
            wlen_next = 3'd0;
            depth_next = '0;
            cnl_next = 1'b0;
            lsf_next = 1'b1;
        end
        held_valid_next = (res.cnt > 3'd2);
        held_next = res.res[2];
        n_push = (res.cnt > 3'd2) ? 2'd2 : res.cnt[1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= M_IDLE;
            pos_reg <= '0;
            tstart_reg <= '0;
            pk_reg <= K_INVALID;
            wbytes_reg <= '0;
            wlen_reg <= 3'd0;
            depth_reg <= '0;
            cnl_reg <= 1'b0;
            lsf_reg <= 1'b1;
            line_reg <= 24'd1;
            held_valid_reg <= 1'b0;
        end else if (s_fire) begin
            mode_reg <= mode_next;
            pos_reg <= pos_next;
            tstart_reg <= tstart_next;
            pk_reg <= pk_next;
            wbytes_reg <= wbytes_next;
            wlen_reg <= wlen_next;
            depth_reg <= depth_next;
            cnl_reg <= cnl_next;
            lsf_reg <= lsf_next;
            line_reg <= line_next;
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire) begin
            held_reg <= held_next;
        end
    end

    // Queue storage: up to two entries written per beat.
    always_ff @(posedge clk)
    begin
        if (s_fire && n_push != 2'd0) begin
            q_mem[q_wr_reg] <= '{tok: res.res[0], last: (n_push == 2'd1)};
        end
        if (s_fire && n_push == 2'd2) begin
            q_mem[q_wr_reg + 2'd1] <= '{tok: res.res[1], last: 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            q_wr_reg <= 2'd0;
            q_rd_reg <= 2'd0;
            q_cnt_reg <= 3'd0;
        end else begin
            if (s_fire) begin
                q_wr_reg <= q_wr_reg + n_push;
            end
            if (m_fire) begin
                q_rd_reg <= q_rd_reg + 2'd1;
            end
            q_cnt_reg <= q_cnt_reg + (s_fire ? {1'b0, n_push} : 3'd0)
                         - (m_fire ? 3'd1 : 3'd0);
        end
    end

    assign m_tvalid = (q_cnt_reg != 3'd0);
    assign m_tuser  = q_mem[q_rd_reg].tok.kind;
    assign m_tdata  = {q_mem[q_rd_reg].tok.line, q_mem[q_rd_reg].tok.len,
                       q_mem[q_rd_reg].tok.start};
    assign m_tlast  = q_mem[q_rd_reg].last;

endmodule
`default_nettype wire

/* rtl/stt_checker.sv */
// Port-level checks for the source text tokenizer, bound to the top level.
// Depends on stt_pkg.
`default_nettype none
module stt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata,
    input wire logic [5:0]  m_tuser,
    input wire logic        m_tlast
);
    import stt_pkg::*;

    // A waiting beat is not withdrawn.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    // A waiting beat keeps its contents.
    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // The input side only stalls while tokens are waiting on the output.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with an empty queue");

    // END has zero length.
    a_end_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == K_END |-> m_tdata[47:24] == 24'd0)
        else $error("END with nonzero length");

    // A newline token spans at most one byte.
    a_nl_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == K_NEWLINE |-> m_tdata[47:24] <= 24'd1)
        else $error("newline token too long");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
    .clk(clk), .rst_n(rst_n), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
);
`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for source_text_tokenizer: streams source bytes and
// end-of-text beats, predicts every token and compares it on the output side.
// Depends on stt_pkg and the tokenizer RTL.
`timescale 1ns / 1ps

module tb_top;
    import stt_pkg::*;

    localparam logic [5:0] K_VAR    = 6'd40;
    localparam logic [5:0] K_CONST  = 6'd41;
    localparam logic [5:0] K_CFFI   = 6'd43;
    localparam logic [5:0] K_FUNC   = 6'd44;
    localparam logic [5:0] K_TRUE   = 6'd45;
    localparam logic [5:0] K_FALSE  = 6'd46;
    localparam logic [5:0] K_RETURN = 6'd47;
    localparam logic [5:0] K_IF     = 6'd48;
    localparam logic [5:0] K_ELSE   = 6'd49;
    localparam logic [5:0] K_CASE   = 6'd50;
    localparam logic [5:0] K_MAIN   = 6'd51;
    localparam logic [5:0] K_FOR    = 6'd52;
    localparam logic [5:0] K_IN     = 6'd53;
    localparam logic [5:0] K_WHILE  = 6'd54;
    localparam logic [5:0] K_STRUCT = 6'd55;
    localparam logic [5:0] K_NIL    = 6'd56;
    localparam logic [5:0] K_REF    = 6'd58;

    localparam int NEST_LIMIT = 255;
    localparam longint unsigned SAT24 = 64'hFFFFFF;
    localparam int CYCLE_LIMIT = 800000;
    localparam int RANDOM_ITEMS = 1350;

    typedef struct {
        logic [5:0]  kind;
        logic [23:0] start;
        logic [23:0] len;
        logic [23:0] line;
        bit          last;
    } token_rec_t;

    class token_scoreboard;
        mode_t           mode;
        longint unsigned pos, line_cnt, tok_start, word_len;
        logic [5:0]      pend_kind;
        logic [47:0]     word;
        int unsigned     depth;
        bit              nl_in_comment, line_head;
        bit              held_valid;
        token_rec_t      held;
        token_rec_t      step_toks[$];
        token_rec_t      due[$];
        int              errors;
        string           kw_word[17];
        logic [5:0]      kw_kind[17];

        function new();
            kw_word = '{"func", "true", "false", "if", "else", "struct", "case", "cffi",
                        "return", "main", "nil", "for", "in", "ref", "var", "const",
                        "while"};
            kw_kind = '{K_FUNC, K_TRUE, K_FALSE, K_IF, K_ELSE, K_STRUCT, K_CASE, K_CFFI,
                        K_RETURN, K_MAIN, K_NIL, K_FOR, K_IN, K_REF, K_VAR, K_CONST,
                        K_WHILE};
            errors = 0;
            held_valid = 0;
            rearm();
        endfunction

        function void rearm();
            mode = M_IDLE;
            pos = 0;
            line_cnt = 1;
            tok_start = 0;
            pend_kind = K_INVALID;
            word = '0;
            word_len = 0;
            depth = 0;
            nl_in_comment = 0;
            line_head = 1;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void push_tok(logic [5:0] k, longint unsigned s, longint unsigned n);
            token_rec_t t;
            t.kind = k;
            t.start = (s > SAT24) ? 24'hFFFFFF : s[23:0];
            t.len = (n > SAT24) ? 24'hFFFFFF : n[23:0];
            t.line = (line_cnt > SAT24) ? 24'hFFFFFF : line_cnt[23:0];
            t.last = 0;
            step_toks.push_back(t);
        endfunction

        function void emit_tok(logic [5:0] k, longint unsigned s, longint unsigned n);
            push_tok(k, s, n);
            line_head = 0;
        endfunction

        function void emit_mark(longint unsigned s);
            push_tok(K_NEWLINE, s, 0);
            nl_in_comment = 0;
            line_head = 1;
        endfunction

        function bit digit_c(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit letter_c(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit wordch_c(logic [7:0] c);
            return letter_c(c) || digit_c(c) || c == "_";
        endfunction

        function bit hexch_c(logic [7:0] c);
            return digit_c(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        endfunction

        function logic [5:0] word_kind();
            bit same;
            for (int i = 0; i < 17; i++) begin
                same = (word_len == kw_word[i].len());
                for (int j = 0; same && j < kw_word[i].len(); j++)
                    if (word[8*j +: 8] != kw_word[i][j])
                        same = 0;
                if (same)
                    return kw_kind[i];
            end
            return K_IDENT;
        endfunction

        // Kind of a two-byte operator completed by c, or K_NONE.
        function logic [5:0] second_byte(mode_t m, logic [7:0] c);
            case (m)
                M_EQ:    return (c == "=") ? K_EQEQ : ((c == ">") ? K_RARROW : K_NONE);
                M_BANG:  return (c == "=") ? K_NOT_EQ : K_NONE;
                M_LT:    return (c == "=") ? K_LTEQ : K_NONE;
                M_GT:    return (c == "=") ? K_GTEQ : K_NONE;
                M_PIPE:  return (c == "|") ? K_LOR : ((c == ">") ? K_PIPE : K_NONE);
                M_AMP:   return (c == "&") ? K_LAND : K_NONE;
                M_COLON: return (c == "=") ? K_COLON_EQ : ((c == ":") ? K_DCOLON : K_NONE);
                default: return K_NONE;
            endcase
        endfunction

        function void open_tok(mode_t m, logic [5:0] k, longint unsigned p);
            mode = m;
            pend_kind = k;
            tok_start = p;
        endfunction

        function void close_tok(longint unsigned p);
            emit_tok((mode == M_IDENT) ? word_kind() : pend_kind, tok_start, p - tok_start);
            mode = M_IDLE;
        endfunction

        function void idle_byte(logic [7:0] c, longint unsigned p);
            if (c == " " || c == "\t" || c == "\r")
                return;
            if (c == "/") begin
                mode = M_SLASH;
                tok_start = p;
                return;
            end
            if (nl_in_comment)
                emit_mark(p);
            case (c)
                "\n":
                begin
                    push_tok(K_NEWLINE, p, 1);
                    if (line_cnt < SAT24)
                        line_cnt++;
                    line_head = 1;
                end
                ";": emit_tok(K_SEMICOLON, p, 1);
                ",": emit_tok(K_COMMA, p, 1);
                "{": emit_tok(K_LBRACE, p, 1);
                "}": emit_tok(K_RBRACE, p, 1);
                "(": emit_tok(K_LPAREN, p, 1);
                ")": emit_tok(K_RPAREN, p, 1);
                "[": emit_tok(K_LSQ, p, 1);
                "]": emit_tok(K_RSQ, p, 1);
                "$": emit_tok(K_DOLLAR, p, 1);
                "+": emit_tok(K_PLUS, p, 1);
                "-": emit_tok(K_MINUS, p, 1);
                "*": emit_tok(K_ASTERISK, p, 1);
                "^": emit_tok(K_XOR, p, 1);
                "?": emit_tok(K_QUESTION, p, 1);
                ".": open_tok(M_DOT, K_DOT, p);
                "=": open_tok(M_EQ, K_EQUALS, p);
                "!": open_tok(M_BANG, K_NOT, p);
                "<": open_tok(M_LT, K_LT, p);
                ">": open_tok(M_GT, K_GT, p);
                "|": open_tok(M_PIPE, K_BOR, p);
                "&": open_tok(M_AMP, K_AMPERSAND, p);
                ":": open_tok(M_COLON, K_COLON, p);
                "#": open_tok(M_HASH, K_INVALID, p);
                "\"": open_tok(M_STRING, K_STRING, p);
                "%":
                begin
                    if (line_head)
                        open_tok(M_DIRECTIVE, K_PERCENT, p);
                    else
                        emit_tok(K_PERCENT, p, 1);
                end
                "0": open_tok(M_ZERO, K_NUM, p);
                default:
                begin
                    if (letter_c(c) || c == "_") begin
                        open_tok(M_IDENT, K_IDENT, p);
                        word = {40'd0, c};
                        word_len = 1;
                    end else if (digit_c(c)) begin
                        open_tok(M_DEC, K_NUM, p);
                    end else begin
                        emit_tok(K_INVALID, p, 1);
                    end
                end
            endcase
        endfunction

        function void scan_byte(logic [7:0] c, longint unsigned p);
            bit again;
            logic [5:0] k;
            again = 1;
            while (again) begin
                again = 0;
                case (mode)
                    M_IDLE: idle_byte(c, p);
                    M_SLASH:
                    begin
                        if (c == "/") begin
                            mode = M_LINECOM;
                        end else if (c == "*") begin
                            mode = M_BLOCK;
                            depth = 1;
                            nl_in_comment = 0;
                        end else begin
                            if (nl_in_comment)
                                emit_mark(tok_start);
                            emit_tok(K_SLASH, tok_start, 1);
                            mode = M_IDLE;
                            again = 1;
                        end
                    end
                    M_LINECOM:
                    begin
                        if (c == "\n") begin
                            mode = M_IDLE;
                            again = 1;
                        end
                    end
                    M_BLOCK:
                    begin
                        if (c == "\n")
                            nl_in_comment = 1;
                        else if (c == "/")
                            mode = M_BLOCK_SLASH;
                        else if (c == "*")
                            mode = M_BLOCK_STAR;
                    end
                    M_BLOCK_SLASH:
                    begin
                        mode = M_BLOCK;
                        if (c == "*") begin
                            if (depth < NEST_LIMIT)
                                depth++;
                        end else begin
                            again = 1;
                        end
                    end
                    M_BLOCK_STAR:
                    begin
                        mode = M_BLOCK;
                        if (c == "/") begin
                            if (depth > 0)
                                depth--;
                            if (depth == 0)
                                mode = M_IDLE;
                        end else begin
                            again = 1;
                        end
                    end
                    M_DOT:
                    begin
                        if (c == ".") begin
                            mode = M_DOTDOT;
                            pend_kind = K_DOTDOT;
                        end else begin
                            close_tok(p);
                            again = 1;
                        end
                    end
                    M_DOTDOT:
                    begin
                        if (c == "=") begin
                            pend_kind = K_DOTDOTEQ;
                            close_tok(p + 1);
                        end else begin
                            close_tok(p);
                            again = 1;
                        end
                    end
                    M_EQ, M_BANG, M_LT, M_GT, M_PIPE, M_AMP, M_COLON:
                    begin
                        k = second_byte(mode, c);
                        if (k != K_NONE) begin
                            pend_kind = k;
                            close_tok(p + 1);
                        end else begin
                            close_tok(p);
                            again = 1;
                        end
                    end
                    M_HASH:
                    begin
                        if (c == "\\") begin
                            mode = M_HASHBS;
                            pend_kind = K_CHARACTER;
                        end else begin
                            close_tok(p);
                            again = 1;
                        end
                    end
                    M_HASHBS: close_tok(p + 1);
                    M_STRING:
                    begin
                        if (c == "\"")
                            close_tok(p + 1);
                    end
                    M_DIRECTIVE:
                    begin
                        if (wordch_c(c)) begin
                            pend_kind = K_DIRECTIVE;
                        end else begin
                            close_tok(p);
                            again = 1;
                        end
                    end
                    M_IDENT:
                    begin
                        if (wordch_c(c)) begin
                            if (word_len < 6)
                                word[8*word_len +: 8] = c;
                            if (word_len < SAT24)
                                word_len++;
                        end else begin
                            close_tok(p);
                            again = 1;
                        end
                    end
                    M_ZERO:
                    begin
                        if (c == "x" || c == "X") begin
                            mode = M_HEX0;
                            pend_kind = K_INVALID;
                        end else if (digit_c(c)) begin
                            mode = M_DEC;
                        end else begin
                            close_tok(p);
                            again = 1;
                        end
                    end
                    M_HEX0:
                    begin
                        if (hexch_c(c)) begin
                            mode = M_HEX;
                            pend_kind = K_NUM;
                        end else begin
                            close_tok(p);
                            again = 1;
                        end
                    end
                    M_HEX:
                    begin
                        if (!hexch_c(c)) begin
                            close_tok(p);
                            again = 1;
                        end
                    end
                    M_DEC:
                    begin
                        if (!digit_c(c)) begin
                            close_tok(p);
                            again = 1;
                        end
                    end
                    default:
                    begin
                        mode = M_IDLE;
                        again = 1;
                    end
                endcase
            end
        endfunction

        function void finish_text(longint unsigned p);
            case (mode)
                M_IDLE, M_LINECOM, M_BLOCK, M_BLOCK_SLASH, M_BLOCK_STAR:
                begin
                    if (nl_in_comment)
                        emit_mark(p);
                end
                M_SLASH:
                begin
                    if (nl_in_comment)
                        emit_mark(tok_start);
                    emit_tok(K_SLASH, tok_start, 1);
                end
                default: close_tok(p);
            endcase
            push_tok(K_END, p, 0);
        endfunction

        // Called for every accepted input beat.
        function void note_input(logic [7:0] c, bit eot);
            step_toks.delete();
            if (held_valid) begin
                step_toks.push_back(held);
                held_valid = 0;
            end
            if (eot) begin
                finish_text(pos);
                rearm();
            end else begin
                scan_byte(c, pos);
                if (pos < SAT24)
                    pos++;
            end
            // A third token waits and leads the next beat's tokens.
            if (step_toks.size() > 2) begin
                held = step_toks[2];
                held_valid = 1;
                step_toks = step_toks[0:1];
            end
            foreach (step_toks[i]) begin
                step_toks[i].last = (i == step_toks.size() - 1);
                due.push_back(step_toks[i]);
            end
        endfunction

        task check_result(logic [5:0] kind, logic [23:0] start, logic [23:0] len,
                          logic [23:0] line, logic last);
            token_rec_t t;
            if (due.size() == 0) begin
                report($sformatf("token kind %0d at %0d with none expected", kind, start));
                return;
            end
            t = due.pop_front();
            if (kind !== t.kind)
                report($sformatf("kind %0d, expected %0d (start %0d)", kind, t.kind, t.start));
            if (start !== t.start)
                report($sformatf("start %0d, expected %0d", start, t.start));
            if (len !== t.len)
                report($sformatf("length %0d, expected %0d (start %0d)", len, t.len, t.start));
            if (line !== t.line)
                report($sformatf("line %0d, expected %0d (start %0d)", line, t.line, t.start));
            if (last !== t.last)
                report($sformatf("tlast %0b, expected %0b (start %0d)", last, t.last, t.start));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [5:0]  m_tuser;
    logic        m_tlast;

    token_scoreboard tokens;
    logic [7:0]      text_q[$];
    int              beats_sent;
    int              cycles;
    bit              src_calm;
    bit              sink_calm;

    source_text_tokenizer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int draw_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    task automatic send_beat(input logic [7:0] c, input bit eot);
        int gap;
        if ($urandom_range(0, 39) == 0)
            src_calm = !src_calm;
        gap = draw_gap(src_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= eot;
        do
            @(posedge clk);
        while (!s_tready);
        tokens.note_input(c, eot);
        beats_sent++;
    endtask

    task automatic send_text();
        while (text_q.size() > 0)
            send_beat(text_q.pop_front(), 1'b0);
        send_beat(8'($urandom), 1'b1);
    endtask

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] word_char();
        string pool;
        pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    function automatic logic [7:0] hex_char();
        string pool;
        pool = "0123456789abcdefABCDEF";
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    // Appends one lexical fragment, mostly well formed, sometimes noise.
    function automatic void add_fragment();
        string kws[17];
        string ops[35];
        int n;
        kws = '{"func", "true", "false", "if", "else", "struct", "case", "cffi",
                "return", "main", "nil", "for", "in", "ref", "var", "const", "while"};
        ops = '{";", ",", "{", "}", "(", ")", "[", "]", "$", "+", "-", "*", "^", "?",
                ".", "..", "..=", "=", "==", "=>", "!", "!=", "<", "<=", ">", ">=",
                "|", "||", "|>", "&", "&&", ":", "::", ":=", "#"};
        case ($urandom_range(0, 15))
            0: add_str(kws[$urandom_range(0, 16)]);
            1:
            begin
                text_q.push_back($urandom_range(0, 1) ? "_" : "q");
                n = $urandom_range(0, 8);
                repeat (n) text_q.push_back(word_char());
            end
            2:
            begin
                n = $urandom_range(1, 5);
                repeat (n) text_q.push_back(8'($urandom_range(48, 57)));
            end
            3:
            begin
                add_str($urandom_range(0, 1) ? "0x" : "0X");
                n = $urandom_range(0, 3);
                repeat (n) text_q.push_back(hex_char());
            end
            4, 5: add_str(ops[$urandom_range(0, 34)]);
            6: add_str($urandom_range(0, 2) == 0 ? "\t" : ($urandom_range(0, 1) ? "\r" : " "));
            7: add_str("\n");
            8:
            begin
                add_str("//");
                n = $urandom_range(0, 6);
                repeat (n) text_q.push_back(8'($urandom_range(32, 126)));
                if ($urandom_range(0, 3) != 0)
                    add_str("\n");
            end
            9:
            begin
                add_str("/*");
                n = $urandom_range(0, 6);
                repeat (n)
                begin
                    case ($urandom_range(0, 4))
                        0: add_str("\n");
                        1: add_str("/*");
                        2: add_str("*/");
                        default: text_q.push_back(8'($urandom_range(32, 126)));
                    endcase
                end
                if ($urandom_range(0, 5) != 0)
                    add_str("*/");
            end
            10:
            begin
                add_str("\"");
                n = $urandom_range(0, 6);
                repeat (n) text_q.push_back(8'($urandom_range(32, 126)));
                if ($urandom_range(0, 5) != 0)
                    add_str("\"");
            end
            11:
            begin
                add_str("#\\");
                if ($urandom_range(0, 7) != 0)
                    text_q.push_back(8'($urandom));
            end
            12:
            begin
                add_str("\n%");
                n = $urandom_range(0, 4);
                repeat (n) text_q.push_back(word_char());
            end
            13: add_str("/");
            default: text_q.push_back(8'($urandom));
        endcase
    endfunction

    // Output side: random back-pressure, every beat checked.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                sink_calm = !sink_calm;
            stall = draw_gap(sink_calm);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            tokens.check_result(m_tuser, m_tdata[23:0], m_tdata[47:24], m_tdata[71:48],
                                m_tlast);
        end
    end

    initial
    begin
        int len;
        tokens = new();
        cycles = 0;
        beats_sent = 0;
        src_calm = 0;
        sink_calm = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Comment newline before a lone slash (three tokens on one beat),
        // directive, hex forms, character literal, a high byte and NUL.
        add_str("/*\n*/ /\n%ab 0x1 0xg #\\q#");
        text_q.push_back(8'hFF);
        text_q.push_back(8'h00);
        send_text();
        // Closed block comment with a newline and a lone slash at end of text.
        add_str("/*\n*/ /");
        send_text();
        add_str("\"open");
        send_text();

        // Nesting deeper than the depth counter can hold.
        repeat (260) add_str("/*");
        add_str("\n");
        repeat (260) add_str("*/");
        send_text();

        while (beats_sent < RANDOM_ITEMS)
        begin
            len = $urandom_range(1, 40);
            repeat (len) add_fragment();
            send_text();
        end
        if (tokens.held_valid)
            send_beat(8'($urandom), 1'b1);
        s_tvalid <= 1'b0;

        while (tokens.due.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (tokens.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
